// ===== src/lsfw_pkg.sv =====
// Shared types and constants for the LED strip fade wipe block.
// No dependencies.
package lsfw_pkg;

  localparam int NumPixels = 256;
  localparam int IdxW      = $clog2(NumPixels);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_LENGTH   = 3'd0,
    REG_FADE     = 3'd1,
    REG_INTERVAL = 3'd2,
    REG_REVERSE  = 3'd3,
    REG_BLACK    = 3'd4,
    REG_TARGET   = 3'd5
  } reg_e;

  // divider request/response between sequencer and divider
  typedef struct packed {
    logic        go;
    logic [16:0] dividend_mag; // |diff*step|, max 255*255
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot_mag;
  } div_rsp_t;

endpackage

// ===== src/lsfw_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on lsfw_pkg.
module lsfw_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsfw_pkg::div_req_t req_i,
  output lsfw_pkg::div_rsp_t rsp_o
);
  import lsfw_pkg::*;

  logic [16:0] quo_q, quo_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [8:0]  trial;
  logic [8:0]  sub;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[16]};
    sub    = trial - {1'b0, den_q};
    if (req_i.go) begin
      quo_d  = req_i.dividend_mag;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!sub[8]) begin
        rem_d = sub[7:0];
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quot_mag = quo_q;
endmodule

// ===== src/led_strip_fade_wipe.sv =====
// LED strip fade wipe top level: pixel memory, sequencer, shared divider.
// Depends on lsfw_pkg and lsfw_div.
//
// Each command is taken while busy is low and answered by one done_o pulse.
// Writes, start and gated ticks go straight to S_DONE; a read passes S_RD. A
// wipe step walks the trail one pixel at a time; each blended channel goes
// through the shared divider (issue, 17 quotient bits, done), four channels per
// blended trail pixel (the pixel that takes the target outright skips it), plus
// the first-step scan (a read and a compare per pixel) and, at the end, a fill
// sweep of one pixel per cycle over the strip. The memory and the divider set
// the pace. Results cannot be held off by the receiver.
module led_strip_fade_wipe (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  pixel_index_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  input  logic [7:0]  in_white_i,
  output logic        done_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_white_o,
  output logic        step_taken_o,
  output logic        finished_o,
  output logic        running_o
);
  import lsfw_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_SCANR = 11'b00000000100,
    S_SCANC = 11'b00000001000,
    S_TRAIL = 11'b00000010000,
    S_TRD   = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_DWAIT = 11'b00010000000,
    S_TWR   = 11'b00100000000,
    S_FILL  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [8:0]  len_q;
  logic [7:0]  fade_q;
  logic [15:0] intv_q;
  logic        rev_q, black_q;
  logic [31:0] tcol_q;

  logic [31:0] mem [NumPixels];
  logic [31:0] rdata_q;
  logic        mem_we;
  logic [IdxW-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd;

  logic [9:0]  pos_q, pos_d;
  logic        ended_q, ended_d, first_q, first_d;
  logic [15:0] ticks_q, ticks_d;
  logic [8:0]  step_q, step_d;   // trail step, also scan/fill counter
  logic [1:0]  ch_q, ch_d;
  logic [31:0] pix_q, pix_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic [31:0] rd_q, rd_d;
  logic        taken_q, taken_d, fin_q, fin_d;

  logic [8:0]  size;
  logic [7:0]  nf;
  logic [31:0] tgt;
  logic [9:0]  end_pos;
  logic [16:0] elapsed;

  div_req_t dreq;
  div_rsp_t drsp;

  lsfw_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign size    = (len_q > 9'(NumPixels)) ? 9'(NumPixels) : len_q;
  assign nf      = (fade_q == 8'd0) ? 8'd1 : fade_q;
  assign tgt     = black_q ? 32'd0 : tcol_q;
  assign end_pos = 10'(size) + 10'(nf) - 10'd1;
  assign elapsed = 17'(ticks_q) + 17'd1;

  function automatic logic [IdxW-1:0] phys(input logic [8:0] i, input logic [8:0] sz,
                                           input logic r);
    logic [8:0] p;
    p = r ? (sz - i - 9'd1) : i;
    return p[IdxW-1:0];
  endfunction

  // trail pixel position: led = pos+1-step
  logic [10:0] led_full;
  logic        led_ok;
  assign led_full = 11'(pos_q) + 11'd1 - 11'(step_q);
  assign led_ok   = !led_full[10] && (led_full[9:0] < 10'(size));

  // channel math for divider
  logic [7:0]  cur_c, tgt_c;
  logic [8:0]  diff;
  logic        dneg;
  logic [7:0]  dmag;
  logic [16:0] prod;
  logic [8:0]  qs;
  logic [7:0]  newc;
  always_comb begin
    cur_c = pix_q[8*ch_q +: 8];
    tgt_c = tgt[8*ch_q +: 8];
    diff  = {1'b0, tgt_c} - {1'b0, cur_c};
    dneg  = diff[8];
    dmag  = dneg ? 8'(-diff) : diff[7:0];
    prod  = 17'(dmag) * 17'(step_q[7:0]);
    qs    = dneg ? 9'(-drsp.quot_mag) : drsp.quot_mag[8:0];
    newc  = cur_c + qs[7:0];
  end
  logic neg_q;

  always_comb begin
    state_d = state_q;
    pos_d = pos_q; ended_d = ended_q; first_d = first_q; ticks_d = ticks_q;
    step_d = step_q; ch_d = ch_q; pix_d = pix_q; addr_d = addr_q;
    rd_d = rd_q; taken_d = taken_q; fin_d = fin_q;
    mem_we = 1'b0; mem_wa = addr_q; mem_wd = pix_q; mem_ra = addr_q;
    dreq.go = 1'b0; dreq.dividend_mag = prod; dreq.divisor = nf;
    unique case (state_q)
      S_IDLE: begin
        mem_ra = pixel_index_i[IdxW-1:0];
        if (start) begin
          rd_d = '0; taken_d = 1'b0; fin_d = 1'b0;
          unique case (cmd_e'(cmd_i))
            CMD_WRITE: begin
              mem_we = 1'b1;
              mem_wa = pixel_index_i[IdxW-1:0];
              mem_wd = {in_red_i, in_green_i, in_blue_i, in_white_i};
              state_d = S_DONE;
            end
            CMD_READ: state_d = S_RD;
            CMD_START: begin
              pos_d = '0; ended_d = 1'b0; first_d = 1'b1; ticks_d = '0;
              state_d = S_DONE;
            end
            default: begin
              if (!first_q && elapsed < 17'(intv_q)) begin
                ticks_d = (ticks_q == 16'hFFFF) ? ticks_q : elapsed[15:0];
                state_d = S_DONE;
              end else begin
                ticks_d = '0; taken_d = 1'b1; first_d = 1'b0;
                if (ended_q) state_d = S_DONE;
                else if (size == 9'd0) begin
                  ended_d = 1'b1; fin_d = 1'b1; state_d = S_DONE;
                end else if (first_q) begin
                  step_d = '0; pos_d = end_pos; state_d = S_SCANR;
                end else begin
                  step_d = 9'd1; state_d = S_TRAIL;
                end
              end
            end
          endcase
        end
      end
      S_RD: begin
        rd_d = rdata_q; state_d = S_DONE;
      end
      S_SCANR: begin
        if (step_q == size) begin
          step_d = 9'd1; state_d = S_TRAIL;
        end else begin
          addr_d = phys(step_q, size, rev_q); mem_ra = addr_d;
          state_d = S_SCANC;
        end
      end
      S_SCANC: begin
        if (rdata_q != tgt) begin
          pos_d = 10'(step_q); step_d = 9'd1; state_d = S_TRAIL;
        end else begin
          step_d = step_q + 9'd1; state_d = S_SCANR;
        end
      end
      S_TRAIL: begin
        if (step_q > 9'(nf)) begin
          if (pos_q < end_pos) pos_d = pos_q + 10'd1;
          if (end_pos <= ((pos_q < end_pos) ? pos_q + 10'd1 : pos_q)) begin
            ended_d = 1'b1; fin_d = 1'b1; step_d = '0; state_d = S_FILL;
          end else state_d = S_DONE;
        end else if (!led_ok) begin
          step_d = step_q + 9'd1;
        end else begin
          addr_d = phys(led_full[8:0], size, rev_q); mem_ra = addr_d;
          state_d = S_TRD;
        end
      end
      S_TRD: begin
        if (step_q >= 9'(nf)) begin
          pix_d = tgt; state_d = S_TWR;
        end else begin
          pix_d = rdata_q; ch_d = 2'd0; state_d = S_DIV;
        end
      end
      S_DIV: begin
        dreq.go = 1'b1; state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (drsp.done) begin
          pix_d[8*ch_q +: 8] = neg_q ? (cur_c - drsp.quot_mag[7:0]) : newc;
          ch_d = ch_q + 2'd1;
          state_d = (ch_q == 2'd3) ? S_TWR : S_DIV;
        end
      end
      S_TWR: begin
        mem_we = 1'b1; step_d = step_q + 9'd1; state_d = S_TRAIL;
      end
      S_FILL: begin
        if (step_q == size) state_d = S_DONE;
        else begin
          mem_we = 1'b1; mem_wa = step_q[IdxW-1:0]; mem_wd = tgt;
          step_d = step_q + 9'd1;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
    if (state_q == S_DIV) neg_q <= dneg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= 9'd256; fade_q <= 8'd4; intv_q <= 16'd32;
      rev_q <= 1'b0; black_q <= 1'b0; tcol_q <= '0;
      pos_q <= '0; ended_q <= 1'b1; first_q <= 1'b0; ticks_q <= '0;
      step_q <= '0; ch_q <= '0; addr_q <= '0;
      rd_q <= '0; taken_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d; ended_q <= ended_d; first_q <= first_d; ticks_q <= ticks_d;
      step_q <= step_d; ch_q <= ch_d; addr_q <= addr_d;
      rd_q <= rd_d; taken_q <= taken_d; fin_q <= fin_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_LENGTH:   len_q   <= cfg_data_i[8:0];
          REG_FADE:     fade_q  <= cfg_data_i[7:0];
          REG_INTERVAL: intv_q  <= cfg_data_i[15:0];
          REG_REVERSE:  rev_q   <= cfg_data_i[0];
          REG_BLACK:    black_q <= cfg_data_i[0];
          REG_TARGET:   tcol_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) pix_q <= pix_d;

  assign busy         = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign out_red_o    = rd_q[31:24];
  assign out_green_o  = rd_q[23:16];
  assign out_blue_o   = rd_q[15:8];
  assign out_white_o  = rd_q[7:0];
  assign step_taken_o = taken_q;
  assign finished_o   = fin_q;
  assign running_o    = !ended_q;

  a_fin_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && finished_o |-> !running_o) else $error("finished while running");
  a_fin_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && finished_o |-> step_taken_o) else $error("finish without step");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
endmodule

// ===== verif/tb_led_strip_fade_wipe.sv =====
// Testbench for led_strip_fade_wipe: pixel write/read, wipe steps with fade trail,
// tick gating, direction and target options, checked against an in-bench predictor.
// Depends on lsfw_pkg and the led_strip_fade_wipe RTL.
module tb_led_strip_fade_wipe;
  import lsfw_pkg::*;

  typedef struct packed {
    logic [7:0] r, g, b, w;
    logic       taken, fin, run;
  } pix_result_t;

  logic        clk_i, rst_ni;
  logic        start;
  logic        busy;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic [1:0]  cmd_i;
  logic [7:0]  pixel_index_i, in_red_i, in_green_i, in_blue_i, in_white_i;
  logic        done_o;
  logic [7:0]  out_red_o, out_green_o, out_blue_o, out_white_o;
  logic        step_taken_o, finished_o, running_o;

  led_strip_fade_wipe i_dut (.*);

  // predictor state
  logic [8:0]  m_len;
  logic [7:0]  m_fade;
  logic [15:0] m_intv;
  logic        m_rev, m_black;
  logic [31:0] m_tgt_color;
  logic [31:0] m_pix [NumPixels];
  bit          m_written [NumPixels];
  int unsigned m_pos;
  bit          m_ended, m_first;
  int unsigned m_ticks;

  pix_result_t expected_q[$];
  int errors, mismatches, results_seen, idle_cycles;
  int burst_left;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] blend_chan(logic [7:0] cur, logic [7:0] tgt, int st, int nf);
    int d, v;
    d = int'(tgt) - int'(cur);
    v = int'(cur) + (d * st) / nf;
    return v[7:0];
  endfunction

  function automatic logic [31:0] blend_pix(logic [31:0] cur, logic [31:0] tgt, int st, int nf);
    logic [31:0] res;
    if (st >= nf) return tgt;
    for (int s = 0; s < 32; s += 8)
      res[s+:8] = blend_chan(cur[s+:8], tgt[s+:8], st, nf);
    return res;
  endfunction

  function automatic int unsigned phys_idx(int unsigned i, int unsigned size);
    return m_rev ? size - i - 1 : i;
  endfunction

  function automatic bit wipe_advance(logic [31:0] tgt, bit initial_step);
    int unsigned nf, size, end_pos, led, p;
    bit found;
    if (m_ended) return 0;
    nf = (m_fade == 0) ? 1 : m_fade;
    size = (m_len > NumPixels) ? NumPixels : m_len;
    if (size == 0) begin
      m_ended = 1;
      return 1;
    end
    if (initial_step) begin
      found = 0;
      m_pos = 0;
      for (int unsigned i = 0; i < size && !found; i++)
        if (m_pix[phys_idx(i, size)] != tgt) begin
          m_pos = i;
          found = 1;
        end
      if (!found) m_pos = size + nf - 1;
    end
    for (int unsigned st = 1; st <= nf; st++) begin
      if (m_pos + 1 < st) continue;
      led = m_pos + 1 - st;
      if (led >= size) continue;
      p = phys_idx(led, size);
      m_pix[p] = blend_pix(m_pix[p], tgt, st, nf);
    end
    end_pos = size + nf - 1;
    if (m_pos < end_pos) m_pos++;
    if (end_pos <= m_pos) begin
      m_ended = 1;
      for (int unsigned i = 0; i < size; i++) m_pix[i] = tgt;
      return 1;
    end
    return 0;
  endfunction

  function automatic pix_result_t predict_cmd(cmd_e c, logic [7:0] idx, logic [31:0] data);
    pix_result_t r;
    logic [31:0] rd;
    int unsigned el;
    r = '0;
    rd = '0;
    case (c)
      CMD_WRITE: begin
        m_pix[idx] = data;
        m_written[idx] = 1;
      end
      CMD_READ: rd = m_pix[idx];
      CMD_START: begin
        m_pos = 0;
        m_ended = 0;
        m_first = 1;
        m_ticks = 0;
      end
      default: begin
        el = (m_ticks < 16'hFFFF) ? m_ticks + 1 : 16'hFFFF;
        if (!m_first && el < m_intv) begin
          m_ticks = el;
        end else begin
          m_ticks = 0;
          r.taken = 1;
          r.fin = wipe_advance(m_black ? 32'h0 : m_tgt_color, m_first);
          m_first = 0;
        end
      end
    endcase
    {r.r, r.g, r.b, r.w} = rd;
    r.run = ~m_ended;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    pix_result_t got, exp_r;
    if (done_o) begin
      got = '{out_red_o, out_green_o, out_blue_o, out_white_o,
              step_taken_o, finished_o, running_o};
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h (r g b w taken fin run)", exp_r, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic cfg_write(reg_e ri, logic [31:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= ri;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (ri)
      REG_LENGTH:   m_len = v[8:0];
      REG_FADE:     m_fade = v[7:0];
      REG_INTERVAL: m_intv = v[15:0];
      REG_REVERSE:  m_rev = v[0];
      REG_BLACK:    m_black = v[0];
      default:      m_tgt_color = v;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_cmd(cmd_e c, logic [7:0] idx = 0, logic [31:0] data = 0);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1;
    cmd_i <= c;
    pixel_index_i <= idx;
    {in_red_i, in_green_i, in_blue_i, in_white_i} <= data;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(predict_cmd(c, idx, data));
    start <= 0;
    // the block goes busy after an accept anyway
    @(posedge clk_i);
  endtask

  task automatic fill_strip(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_cmd(CMD_WRITE, i[7:0], $urandom());
  endtask

  task automatic test_pixel_access();
    send_cmd(CMD_WRITE, 8'd0, 32'h0000_0000);
    send_cmd(CMD_WRITE, 8'd255, 32'hFFFF_FFFF);
    send_cmd(CMD_WRITE, 8'd7, 32'hA55A_3CC3);
    send_cmd(CMD_READ, 8'd0);
    send_cmd(CMD_READ, 8'd255);
    send_cmd(CMD_READ, 8'd7);
    wait_drained();
  endtask

  task automatic test_directed_wipe();
    cfg_write(REG_LENGTH, 9'd4);
    cfg_write(REG_FADE, 8'd0);
    cfg_write(REG_INTERVAL, 16'd0);
    cfg_write(REG_REVERSE, 1'b0);
    cfg_write(REG_BLACK, 1'b0);
    cfg_write(REG_TARGET, 32'hFFFF_FFFF);
    send_cmd(CMD_TICK);                    // tick while no wipe runs
    fill_strip(4);
    send_cmd(CMD_START);
    repeat (6) send_cmd(CMD_TICK);
    send_cmd(CMD_READ, 8'd2);
    // no differing pixel: finish on the first tick
    send_cmd(CMD_START);
    send_cmd(CMD_TICK);
    wait_drained();
    cfg_write(REG_LENGTH, 9'd0);           // empty strip
    send_cmd(CMD_START);
    send_cmd(CMD_TICK);
    wait_drained();
  endtask

  task automatic test_random_wipes();
    int unsigned len, n;
    logic [31:0] tc;
    for (int k = 0; k < 15; k++) begin
      len = $urandom_range(1, 12);
      if (k == 5) len = 256;
      if (k == 9) len = 300;                       // above strip size
      tc = $urandom();
      cfg_write(REG_LENGTH, len);
      cfg_write(REG_FADE, (k == 6) ? 8'd255 : $urandom_range(0, 5));
      cfg_write(REG_INTERVAL, (k == 7) ? 16'hFFFF : $urandom_range(0, 3));
      cfg_write(REG_REVERSE, (len > 12) ? 1'b0 : 1'($urandom_range(0, 1)));
      cfg_write(REG_BLACK, $urandom_range(0, 1));
      cfg_write(REG_TARGET, tc);
      n = (len > 12) ? 12 : len;
      fill_strip(n);
      // long strip: pixel 0 differs, so the head stays within the written front
      if (len > 12) send_cmd(CMD_WRITE, 8'd0, ~(m_black ? 32'h0 : tc));
      send_cmd(CMD_START);
      for (int t = 0; t < 10; t++) begin
        case ($urandom_range(0, 5))
          0: send_cmd(CMD_WRITE, 8'($urandom_range(0, n - 1)), $urandom());
          1: send_cmd(CMD_READ, 8'($urandom_range(0, n - 1)));
          default: send_cmd(CMD_TICK);
        endcase
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_ni = 0;
    start = 0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cmd_i = '0;
    pixel_index_i = '0;
    {in_red_i, in_green_i, in_blue_i, in_white_i} = '0;
    errors = 0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    burst_left = 0;
    m_len = 256;
    m_fade = 4;
    m_intv = 32;
    m_rev = 0;
    m_black = 0;
    m_tgt_color = 0;
    m_pos = 0;
    m_ended = 1;
    m_first = 0;
    m_ticks = 0;
    for (int i = 0; i < NumPixels; i++) begin
      m_pix[i] = '0;
      m_written[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_pixel_access();
    test_directed_wipe();
    test_random_wipes();
    wait_drained();
    $display("covered %0d results: pixel access, wipes with both directions and targets,",
             results_seen);
    $display("fade lengths up to 255, interval extremes and an empty strip");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
